/* rtl/urtrb_pkg.sv */
// Shared types and constants for the UART transceiver with receive ring buffer.
// Used by every module and interface of the block except urtrb_ram; depends on nothing.
package urtrb_pkg;

  localparam int BIT_TICKS_W      = 16;
  localparam int BYTE_W           = 8;
  localparam int COUNT_W          = 6;
  localparam int RX_TIMER_W       = 17;
  localparam int DATA_BITS        = 8;
  localparam int FRAME_BITS       = 10;
  localparam int BIT_CNT_W        = 4;
  localparam int CFG_INDEX_W      = 2;
  localparam int BUFFER_DEPTH_DEF = 64;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_BIT_TICKS = 2'd0,
    CFG_INVERSE   = 2'd1,
    CFG_LISTEN    = 2'd2
  } cfg_index_e;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
  } rx_push_t;

  typedef struct packed {
    logic               ready;
    logic [BYTE_W-1:0]  head_byte;
    logic [COUNT_W-1:0] count;
    logic               overflow;
  } ring_stat_t;

  typedef struct packed {
    logic level;
    logic busy;
    logic accepted;
  } tx_stat_t;

endpackage

/* rtl/urtrb_item_if.sv */
// Input channel interface: one word per line tick.
// Depends on urtrb_pkg.
interface urtrb_item_if
  import urtrb_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              rx_line;
  logic              send;
  logic [BYTE_W-1:0] tx_byte;
  logic              pop_req;
  logic              clear_overflow;

  modport source (output valid, rx_line, send, tx_byte, pop_req, clear_overflow,
                  input ready);
  modport sink   (input valid, rx_line, send, tx_byte, pop_req, clear_overflow,
                  output ready);
endinterface

/* rtl/urtrb_result_if.sv */
// Result channel interface: line level and receive buffer status per tick.
// Depends on urtrb_pkg.
interface urtrb_result_if
  import urtrb_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               tx_line;
  logic [BYTE_W-1:0]  rx_byte;
  logic               rx_ready;
  logic [COUNT_W-1:0] rx_count;
  logic               overflow;
  logic               tx_busy;
  logic               send_accepted;

  modport source (output valid, tx_line, rx_byte, rx_ready, rx_count, overflow, tx_busy,
                  send_accepted, input ready);
  modport sink   (input valid, tx_line, rx_byte, rx_ready, rx_count, overflow, tx_busy,
                  send_accepted, output ready);
endinterface

/* rtl/uart_rx_tx_with_ring_buffer_top.sv */
// A result word is presented in the cycle after its input word is accepted.
// Throughput: one word per cycle; a new word is taken in the cycle the previous result
// leaves, and a waiting result holds the input back. The head byte comes from a
// registered-read RAM whose address follows the next head pointer. Reset is asynchronous
// and active low; it clears control state and the configuration. Buffer contents stay
// undefined, and only entries written since the last empty state are ever shown.
module uart_rx_tx_with_ring_buffer_top
  import urtrb_pkg::*;
#(
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  urtrb_item_if.sink             item_i,
  urtrb_result_if.source         result_o,
  input  logic                   cfg_we_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [BIT_TICKS_W-1:0] cfg_data_i
);
  logic [BIT_TICKS_W-1:0] bit_ticks_q, bit_ticks_d;
  logic                   inverse_q, inverse_d;
  logic                   listen_q, listen_d;
  logic                   clear_all;
  logic                   accept;
  logic                   out_valid_q, out_valid_d;
  rx_push_t               push;
  ring_stat_t             ring_stat;
  tx_stat_t               tx_stat;
  ring_stat_t             ring_res_q;
  tx_stat_t               tx_res_q;

  always_comb begin
    bit_ticks_d = bit_ticks_q;
    inverse_d   = inverse_q;
    listen_d    = listen_q;
    clear_all   = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_BIT_TICKS: bit_ticks_d = cfg_data_i;
        CFG_INVERSE:   inverse_d   = cfg_data_i[0];
        CFG_LISTEN: begin
          listen_d  = cfg_data_i[0];
          clear_all = cfg_data_i[0] & ~listen_q;
        end
        default: ;
      endcase
    end
  end

  assign item_i.ready = ~out_valid_q | result_o.ready;
  assign accept       = item_i.valid & item_i.ready;

  urtrb_rx u_rx (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tick_i      (accept),
    .line_i      (item_i.rx_line),
    .bit_ticks_i (bit_ticks_q),
    .inverse_i   (inverse_q),
    .listen_i    (listen_q),
    .push_o      (push)
  );

  urtrb_ring #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_ring (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tick_i      (accept),
    .push_i      (push),
    .pop_i       (item_i.pop_req),
    .clear_ovf_i (item_i.clear_overflow),
    .clear_all_i (clear_all),
    .listen_i    (listen_q),
    .stat_o      (ring_stat)
  );

  urtrb_tx u_tx (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tick_i      (accept),
    .send_i      (item_i.send),
    .tx_byte_i   (item_i.tx_byte),
    .bit_ticks_i (bit_ticks_q),
    .inverse_i   (inverse_q),
    .stat_o      (tx_stat)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ring_res_q <= ring_stat;
      tx_res_q   <= tx_stat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_ticks_q <= '0;
      inverse_q   <= 1'b0;
      listen_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      bit_ticks_q <= bit_ticks_d;
      inverse_q   <= inverse_d;
      listen_q    <= listen_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.tx_line       = tx_res_q.level;
  assign result_o.rx_byte       = ring_res_q.head_byte;
  assign result_o.rx_ready      = ring_res_q.ready;
  assign result_o.rx_count      = ring_res_q.count;
  assign result_o.overflow      = ring_res_q.overflow;
  assign result_o.tx_busy       = tx_res_q.busy;
  assign result_o.send_accepted = tx_res_q.accepted;

`ifndef SYNTHESIS
  a_result_follows_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted word produced no result");
  a_stalled_result_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !result_o.ready) |-> !accept)
    else $error("input taken while the result register was full");
`endif
endmodule

/* rtl/urtrb_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Read returns the old contents when the same address is written. No dependencies.
module urtrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

/* rtl/urtrb_rx.sv */
// Serial receiver: start detection, bit timing and data sampling.
// Produces one push word per completed byte. Depends on urtrb_pkg.
module urtrb_rx
  import urtrb_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   tick_i,
  input  logic                   line_i,
  input  logic [BIT_TICKS_W-1:0] bit_ticks_i,
  input  logic                   inverse_i,
  input  logic                   listen_i,
  output rx_push_t               push_o
);
  logic                  busy_q, busy_d, busy_n;
  logic [RX_TIMER_W-1:0] timer_q, timer_d, timer_n;
  logic [BYTE_W-1:0]     shift_q, shift_d, shift_n;
  logic [BIT_CNT_W-1:0]  cnt_q, cnt_d, cnt_n;
  logic [BIT_TICKS_W+1:0] three_bt;
  logic                  push_n;

  assign three_bt = {bit_ticks_i, 1'b0} + (BIT_TICKS_W+2)'(bit_ticks_i);

  always_comb begin
    busy_n  = busy_q;
    timer_n = timer_q;
    shift_n = shift_q;
    cnt_n   = cnt_q;
    push_n  = 1'b0;
    if (!listen_i || bit_ticks_i == '0) begin
      busy_n  = 1'b0;
      timer_n = '0;
      cnt_n   = '0;
    end else if (!busy_q) begin
      if (line_i == inverse_i) begin
        busy_n  = 1'b1;
        timer_n = RX_TIMER_W'(bit_ticks_i) + RX_TIMER_W'(bit_ticks_i >> 1);
        cnt_n   = '0;
        shift_n = '0;
      end
    end else begin
      timer_n = (timer_q != '0) ? timer_q - 1'b1 : '0;
      if (timer_n == '0) begin
        if (cnt_q < BIT_CNT_W'(DATA_BITS)) begin
          shift_n = {line_i, shift_q[BYTE_W-1:1]};
          cnt_n   = cnt_q + 1'b1;
          if (cnt_n == BIT_CNT_W'(DATA_BITS)) begin
            push_n  = 1'b1;
            timer_n = RX_TIMER_W'(three_bt[BIT_TICKS_W+1:2]);
            if (timer_n == '0) begin
              busy_n = 1'b0;
            end
          end else begin
            timer_n = RX_TIMER_W'(bit_ticks_i);
          end
        end else begin
          busy_n = 1'b0;
        end
      end
    end
  end

  assign busy_d  = tick_i ? busy_n : busy_q;
  assign timer_d = tick_i ? timer_n : timer_q;
  assign shift_d = tick_i ? shift_n : shift_q;
  assign cnt_d   = tick_i ? cnt_n : cnt_q;

  assign push_o.valid = tick_i & push_n;
  assign push_o.data  = inverse_i ? ~shift_n : shift_n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      timer_q <= '0;
      shift_q <= '0;
      cnt_q   <= '0;
    end else begin
      busy_q  <= busy_d;
      timer_q <= timer_d;
      shift_q <= shift_d;
      cnt_q   <= cnt_d;
    end
  end

`ifndef SYNTHESIS
  a_push_on_last_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.valid |-> (busy_q && cnt_q == BIT_CNT_W'(DATA_BITS - 1)))
    else $error("receiver pushed a byte before the last data bit");
`endif
endmodule

/* rtl/urtrb_tx.sv */
// Serial transmitter: start bit, eight data bits and stop bit per frame.
// Reports line level, busy and whether a send started a frame. Depends on urtrb_pkg.
module urtrb_tx
  import urtrb_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   tick_i,
  input  logic                   send_i,
  input  logic [BYTE_W-1:0]      tx_byte_i,
  input  logic [BIT_TICKS_W-1:0] bit_ticks_i,
  input  logic                   inverse_i,
  output tx_stat_t               stat_o
);
  logic [FRAME_BITS-1:0]  shift_q, shift_d, shift_n;
  logic [BIT_TICKS_W-1:0] timer_q, timer_d, timer_n;
  logic [BIT_CNT_W-1:0]   cnt_q, cnt_d, cnt_n;
  logic                   acc_n;
  logic                   busy_n;

  always_comb begin
    shift_n = shift_q;
    timer_n = timer_q;
    cnt_n   = cnt_q;
    acc_n   = 1'b0;
    if (bit_ticks_i == '0) begin
      cnt_n   = '0;
      timer_n = '0;
    end else if (cnt_q != '0) begin
      timer_n = (timer_q != '0) ? timer_q - 1'b1 : '0;
      if (timer_n == '0) begin
        shift_n = shift_q >> 1;
        cnt_n   = cnt_q - 1'b1;
        if (cnt_n != '0) begin
          timer_n = bit_ticks_i;
        end
      end
    end
    if (bit_ticks_i != '0 && cnt_n == '0 && send_i) begin
      shift_n = {1'b1, tx_byte_i, 1'b0};
      cnt_n   = BIT_CNT_W'(FRAME_BITS);
      timer_n = bit_ticks_i;
      acc_n   = 1'b1;
    end
  end

  assign busy_n = (cnt_n != '0);

  assign stat_o.busy     = busy_n;
  assign stat_o.level    = busy_n ? (shift_n[0] ^ inverse_i) : ~inverse_i;
  assign stat_o.accepted = tick_i & acc_n;

  assign shift_d = tick_i ? shift_n : shift_q;
  assign timer_d = tick_i ? timer_n : timer_q;
  assign cnt_d   = tick_i ? cnt_n : cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= '0;
      timer_q <= '0;
      cnt_q   <= '0;
    end else begin
      shift_q <= shift_d;
      timer_q <= timer_d;
      cnt_q   <= cnt_d;
    end
  end

`ifndef SYNTHESIS
  a_start_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.accepted |-> (cnt_q == '0 || (cnt_q == 1'b1 && timer_q <= 1'b1)))
    else $error("transmitter started a frame while one was still running");
  a_disable_stops_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tick_i && bit_ticks_i == '0) |=> (cnt_q == '0))
    else $error("frame kept running with a zero bit time");
`endif
endmodule

/* rtl/urtrb_ring.sv */
// Receive ring buffer: head and tail pointers, sticky overflow and status.
// Storage is one urtrb_ram instance with a write-to-read bypass. Depends on urtrb_pkg.
module urtrb_ring
  import urtrb_pkg::*;
#(
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       tick_i,
  input  rx_push_t   push_i,
  input  logic       pop_i,
  input  logic       clear_ovf_i,
  input  logic       clear_all_i,
  input  logic       listen_i,
  output ring_stat_t stat_o
);
  localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

  logic [AW-1:0]     head_q, head_d, tail_q, tail_d;
  logic [AW-1:0]     head_inc, tail_inc, tail_new;
  logic              ovf_q, ovf_d, ovf_new;
  logic              full, push_ok;
  logic [AW:0]       diff;
  logic [AW:0]       fill;
  logic              ready;
  logic [BYTE_W-1:0] ram_rdata, fwd_data_q, head_raw;
  logic              fwd_q;

  assign tail_inc = (tail_q == AW'(BUFFER_DEPTH - 1)) ? '0 : tail_q + 1'b1;
  assign head_inc = (head_q == AW'(BUFFER_DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign full     = (tail_inc == head_q);
  assign push_ok  = tick_i & push_i.valid & ~full;
  assign tail_new = push_ok ? tail_inc : tail_q;
  assign ovf_new  = ovf_q | (tick_i & push_i.valid & full);

  assign diff = (tail_new >= head_q) ? ({1'b0, tail_new} - {1'b0, head_q})
              : ({1'b0, tail_new} + (AW+1)'(BUFFER_DEPTH) - {1'b0, head_q});
  assign fill  = listen_i ? diff : '0;
  assign ready = (fill != '0);

  assign head_raw = (push_ok && tail_q == head_q) ? push_i.data
                  : (fwd_q ? fwd_data_q : ram_rdata);

  assign stat_o.ready     = ready;
  assign stat_o.head_byte = ready ? head_raw : '0;
  assign stat_o.count     = COUNT_W'(fill);
  assign stat_o.overflow  = ovf_new;

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    ovf_d  = ovf_q;
    if (clear_all_i) begin
      head_d = '0;
      tail_d = '0;
      ovf_d  = 1'b0;
    end else if (tick_i) begin
      tail_d = tail_new;
      ovf_d  = clear_ovf_i ? 1'b0 : ovf_new;
      if (pop_i && ready) begin
        head_d = head_inc;
      end
    end
  end

  urtrb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BUFFER_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (push_ok),
    .waddr_i (tail_q),
    .wdata_i (push_i.data),
    .raddr_i (head_d),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    fwd_data_q <= push_i.data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      ovf_q  <= 1'b0;
      fwd_q  <= 1'b0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      ovf_q  <= ovf_d;
      fwd_q  <= push_ok && (tail_q == head_d);
    end
  end

`ifndef SYNTHESIS
  a_overflow_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovf_q) |-> $past(full && push_i.valid && tick_i))
    else $error("overflow set while the ring had room");
  a_no_push_into_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_ok |-> (tail_inc != head_q))
    else $error("byte written into a full ring");
`endif
endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the UART transceiver with receive ring buffer.
// Drives line ticks and configuration writes, predicts every status word and checks it.
// Depends on urtrb_pkg, urtrb_item_if, urtrb_result_if and uart_rx_tx_with_ring_buffer_top.
module tb_top
  import urtrb_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_DEPTH = BUFFER_DEPTH_DEF;

  typedef struct packed {
    logic              rx_line;
    logic              send;
    logic [BYTE_W-1:0] tx_byte;
    logic              pop_req;
    logic              clear_overflow;
  } tick_t;

  typedef struct packed {
    logic               tx_line;
    logic [BYTE_W-1:0]  rx_byte;
    logic               rx_ready;
    logic [COUNT_W-1:0] rx_count;
    logic               overflow;
    logic               tx_busy;
    logic               send_accepted;
  } status_t;

  typedef enum int {PRESS_NONE, PRESS_SOURCE, PRESS_SINK, PRESS_BOTH} pressure_e;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_INDEX_W-1:0] cfg_index_i;
  logic [BIT_TICKS_W-1:0] cfg_data_i;

  urtrb_item_if   item_bus ();
  urtrb_result_if result_bus ();

  uart_rx_tx_with_ring_buffer_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_bus),
    .result_o    (result_bus),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Predictor copy of the configuration and the block state.
  logic [BIT_TICKS_W-1:0] cfg_bit_ticks = '0;
  logic                   cfg_inverse   = 1'b0;
  logic                   cfg_listen    = 1'b0;
  logic                   rx_busy       = 1'b0;
  int unsigned            rx_timer      = 0;
  logic [BYTE_W-1:0]      rx_shift      = '0;
  int unsigned            rx_bits       = 0;
  logic [BYTE_W-1:0]      ring_bytes [RING_DEPTH];
  int unsigned            ring_head     = 0;
  int unsigned            ring_tail     = 0;
  logic                   overflow_flag = 1'b0;
  logic [FRAME_BITS-1:0]  tx_shift      = '0;
  int unsigned            tx_timer      = 0;
  int unsigned            tx_bits       = 0;

  status_t pending_status [$];
  int      mismatch_count  = 0;
  int      sender_idle_pct = 0;
  int      sink_stall_pct  = 0;
  int      send_pct        = 0;
  int      pop_pct         = 0;
  int      clr_pct         = 0;

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  function automatic status_t predict_line_tick(tick_t t);
    status_t     s;
    int unsigned bt;
    int unsigned nxt;
    int unsigned fill;
    logic        inv;
    bt  = 32'(cfg_bit_ticks);
    inv = cfg_inverse;
    s   = '0;

    if (!cfg_listen || bt == 0) begin
      rx_busy  = 1'b0;
      rx_timer = 0;
      rx_bits  = 0;
    end else if (!rx_busy) begin
      if (t.rx_line == inv) begin
        rx_busy  = 1'b1;
        rx_timer = bt + bt / 2;
        rx_bits  = 0;
        rx_shift = '0;
      end
    end else begin
      if (rx_timer > 0) rx_timer--;
      if (rx_timer == 0) begin
        if (rx_bits < DATA_BITS) begin
          rx_shift = {t.rx_line, rx_shift[BYTE_W-1:1]};
          rx_bits++;
          if (rx_bits == DATA_BITS) begin
            nxt = (ring_tail + 1) % RING_DEPTH;
            if (nxt != ring_head) begin
              ring_bytes[ring_tail] = inv ? ~rx_shift : rx_shift;
              ring_tail = nxt;
            end else begin
              overflow_flag = 1'b1;
            end
            rx_timer = bt * 3 / 4;
            if (rx_timer == 0) rx_busy = 1'b0;
          end else begin
            rx_timer = bt;
          end
        end else begin
          rx_busy = 1'b0;
        end
      end
    end

    if (bt == 0) begin
      tx_bits  = 0;
      tx_timer = 0;
    end else if (tx_bits != 0) begin
      if (tx_timer > 0) tx_timer--;
      if (tx_timer == 0) begin
        tx_shift = tx_shift >> 1;
        tx_bits--;
        if (tx_bits != 0) tx_timer = bt;
      end
    end
    if (bt != 0 && tx_bits == 0 && t.send) begin
      tx_shift        = {1'b1, t.tx_byte, 1'b0};
      tx_bits         = FRAME_BITS;
      tx_timer        = bt;
      s.send_accepted = 1'b1;
    end
    s.tx_busy = (tx_bits != 0);
    s.tx_line = s.tx_busy ? (tx_shift[0] ^ inv) : ~inv;

    fill       = cfg_listen ? (ring_tail + RING_DEPTH - ring_head) % RING_DEPTH : 0;
    s.rx_ready = (fill != 0);
    s.rx_count = fill[COUNT_W-1:0];
    s.rx_byte  = s.rx_ready ? ring_bytes[ring_head] : '0;
    s.overflow = overflow_flag;

    if (t.pop_req && s.rx_ready) ring_head = (ring_head + 1) % RING_DEPTH;
    if (t.clear_overflow) overflow_flag = 1'b0;
    return s;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  always @(posedge clk_i) begin : scoreboard
    tick_t   seen;
    status_t want;
    if (rst_ni && item_bus.valid && item_bus.ready) begin
      seen.rx_line        = item_bus.rx_line;
      seen.send           = item_bus.send;
      seen.tx_byte        = item_bus.tx_byte;
      seen.pop_req        = item_bus.pop_req;
      seen.clear_overflow = item_bus.clear_overflow;
      pending_status.push_back(predict_line_tick(seen));
    end
    if (rst_ni && result_bus.valid && result_bus.ready) begin
      if (pending_status.size() == 0) begin
        report_mismatch("status word arrived with nothing pending");
      end else begin
        want = pending_status.pop_front();
        check_field("tx_line", 8'(result_bus.tx_line), 8'(want.tx_line));
        check_field("rx_byte", result_bus.rx_byte, want.rx_byte);
        check_field("rx_ready", 8'(result_bus.rx_ready), 8'(want.rx_ready));
        check_field("rx_count", 8'(result_bus.rx_count), 8'(want.rx_count));
        check_field("overflow", 8'(result_bus.overflow), 8'(want.overflow));
        check_field("tx_busy", 8'(result_bus.tx_busy), 8'(want.tx_busy));
        check_field("send_accepted", 8'(result_bus.send_accepted),
                    8'(want.send_accepted));
      end
    end
  end

  always @(negedge clk_i) begin
    result_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  task automatic set_pressure(input pressure_e mode);
    case (mode)
      PRESS_SOURCE: begin
        sender_idle_pct = 61;
        sink_stall_pct  = 0;
      end
      PRESS_SINK: begin
        sender_idle_pct = 0;
        sink_stall_pct  = 61;
      end
      PRESS_BOTH: begin
        sender_idle_pct = 7;
        sink_stall_pct  = 7;
      end
      default: begin
        sender_idle_pct = 0;
        sink_stall_pct  = 0;
      end
    endcase
  endtask

  task automatic send_tick(input logic line, input logic send, input logic [7:0] tx_data,
                           input logic pop, input logic clr);
    while ($urandom_range(99) < sender_idle_pct) begin
      item_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    item_bus.valid          <= 1'b1;
    item_bus.rx_line        <= line;
    item_bus.send           <= send;
    item_bus.tx_byte        <= tx_data;
    item_bus.pop_req        <= pop;
    item_bus.clear_overflow <= clr;
    do @(posedge clk_i); while (!item_bus.ready);
    @(negedge clk_i);
  endtask

  task automatic random_tick(input logic line);
    send_tick(line, $urandom_range(99) < send_pct, 8'($urandom_range(255)),
              $urandom_range(99) < pop_pct, $urandom_range(99) < clr_pct);
  endtask

  task automatic rx_frame(input logic [7:0] rx_data, input int unsigned bit_len,
                          input int unsigned max_ticks);
    logic [FRAME_BITS-1:0] levels;
    int unsigned           sent;
    levels = {1'b1, rx_data, 1'b0} ^ {FRAME_BITS{cfg_inverse}};
    sent   = 0;
    for (int i = 0; i < FRAME_BITS; i++) begin
      for (int k = 0; k < bit_len; k++) begin
        if (sent < max_ticks) begin
          random_tick(levels[i]);
          sent++;
        end
      end
    end
  endtask

  task automatic finish_words();
    item_bus.valid <= 1'b0;
    while (pending_status.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic cfg_write(input cfg_index_e idx, input logic [BIT_TICKS_W-1:0] value);
    finish_words();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_BIT_TICKS: cfg_bit_ticks = value;
      CFG_INVERSE:   cfg_inverse = value[0];
      CFG_LISTEN: begin
        if (value[0] && !cfg_listen) begin
          ring_head     = 0;
          ring_tail     = 0;
          overflow_flag = 1'b0;
        end
        cfg_listen = value[0];
      end
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic test_disabled_after_reset();
    set_pressure(PRESS_NONE);
    send_tick(1'b0, 1'b1, 8'h00, 1'b1, 1'b1);
    send_tick(1'b1, 1'b1, 8'hFF, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, 8'h5A, 1'b1, 1'b0);
  endtask

  task automatic test_extreme_bit_time();
    set_pressure(PRESS_NONE);
    cfg_write(CFG_LISTEN, 16'd1);
    cfg_write(CFG_INVERSE, 16'd1);
    cfg_write(CFG_BIT_TICKS, 16'hFFFF);
    send_tick(1'b1, 1'b1, 8'hFF, 1'b1, 1'b1);
    send_tick(1'b1, 1'b1, 8'h00, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, 8'hA5, 1'b1, 1'b0);
    cfg_write(CFG_BIT_TICKS, 16'd0);
    send_tick(1'b0, 1'b1, 8'h3C, 1'b0, 1'b0);
    send_tick(1'b1, 1'b1, 8'hC3, 1'b1, 1'b1);
    cfg_write(CFG_INVERSE, 16'd0);
  endtask

  task automatic test_single_frame();
    set_pressure(PRESS_NONE);
    cfg_write(CFG_BIT_TICKS, 16'd1);
    send_pct = 100;
    pop_pct  = 0;
    clr_pct  = 0;
    rx_frame(8'hA5, 1, FRAME_BITS);
    send_tick(1'b1, 1'b1, 8'h00, 1'b1, 1'b1);
    cfg_write(CFG_LISTEN, 16'd0);
    send_tick(1'b1, 1'b0, 8'hFF, 1'b1, 1'b0);
    cfg_write(CFG_LISTEN, 16'd1);
    send_tick(1'b1, 1'b0, 8'h00, 1'b0, 1'b0);
  endtask

  task automatic test_ring_overflow();
    set_pressure(PRESS_SOURCE);
    cfg_write(CFG_BIT_TICKS, 16'd1);
    cfg_write(CFG_INVERSE, 16'd0);
    cfg_write(CFG_LISTEN, 16'd0);
    cfg_write(CFG_LISTEN, 16'd1);
    send_pct = 30;
    pop_pct  = 0;
    clr_pct  = 0;
    repeat (RING_DEPTH + 2) begin
      rx_frame(8'($urandom_range(255)), 1, FRAME_BITS);
      repeat ($urandom_range(2)) random_tick(~cfg_inverse);
    end
    clr_pct = 100;
    random_tick(~cfg_inverse);
    clr_pct = 0;
    pop_pct = 90;
    repeat (RING_DEPTH + 8) random_tick(~cfg_inverse);
  endtask

  task automatic retune_midframe();
    int unsigned bt;
    int unsigned pick;
    bt   = 32'(cfg_bit_ticks);
    pick = $urandom_range(2);
    rx_frame(8'($urandom_range(255)), bt, $urandom_range(FRAME_BITS * bt - 1, 1));
    case (pick)
      0: cfg_write(CFG_BIT_TICKS, BIT_TICKS_W'($urandom_range(4, 1)));
      1: cfg_write(CFG_INVERSE, BIT_TICKS_W'(!cfg_inverse));
      default: begin
        cfg_write(CFG_LISTEN, 16'd0);
        repeat (2) random_tick(~cfg_inverse);
        cfg_write(CFG_LISTEN, 16'd1);
      end
    endcase
  endtask

  task automatic test_random_traffic();
    int unsigned bt;
    int unsigned pick;
    for (int p = 0; p < 4; p++) begin
      set_pressure(pressure_e'(p));
      cfg_write(CFG_BIT_TICKS, BIT_TICKS_W'($urandom_range(3, 1)));
      cfg_write(CFG_INVERSE, BIT_TICKS_W'(p[0]));
      send_pct = 20;
      pop_pct  = 35;
      clr_pct  = 5;
      repeat (6) begin
        bt   = 32'(cfg_bit_ticks);
        pick = $urandom_range(99);
        if (pick < 65) begin
          rx_frame(8'($urandom_range(255)), bt, FRAME_BITS * bt);
          repeat ($urandom_range(bt)) random_tick(~cfg_inverse);
        end else if (pick < 78) begin
          rx_frame(8'($urandom_range(255)), bt + 1,
                   $urandom_range(FRAME_BITS * (bt + 1), 1));
        end else if (pick < 88) begin
          repeat ($urandom_range(4, 1)) random_tick(1'($urandom_range(1)));
        end else begin
          retune_midframe();
        end
      end
    end
  endtask

  initial begin
    rst_ni                  = 1'b0;
    cfg_we_i                = 1'b0;
    cfg_index_i             = CFG_BIT_TICKS;
    cfg_data_i              = '0;
    item_bus.valid          = 1'b0;
    item_bus.rx_line        = 1'b1;
    item_bus.send           = 1'b0;
    item_bus.tx_byte        = '0;
    item_bus.pop_req        = 1'b0;
    item_bus.clear_overflow = 1'b0;
    result_bus.ready        = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_disabled_after_reset();
    test_extreme_bit_time();
    test_single_frame();
    test_ring_overflow();
    test_random_traffic();

    finish_words();
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
